### rtl/set_pkg.sv
// ----------------------------------------------------------------------------
// set_pkg
// Shared widths, register indexes and the per-item result tag of the Sobel
// edge threshold block.
// ----------------------------------------------------------------------------
package set_pkg;

   localparam int PIX_W      = 8;
   localparam int LINE_W     = 2 * PIX_W;
   localparam int COORD_W    = 12;
   localparam int MAG_W      = 10;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int TH_W       = 11;
   localparam int TH2_W      = 2 * TH_W;
   localparam int HEIGHT_W   = 13;
   localparam int MAX_HEIGHT = 4096;
   localparam int MIN_SIZE   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_THRESHOLD = 2'd2;

   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
   localparam logic [TH2_W-1:0]    TH2_RESET    = 22'd10000;

   // results an item causes, with their coordinates already masked
   typedef struct packed {
      logic               calc;
      logic               has_norm;
      logic               has_right;
      logic               has_bot;
      logic [COORD_W-1:0] col_norm;
      logic [COORD_W-1:0] row_norm;
      logic [COORD_W-1:0] col_right;
      logic [COORD_W-1:0] col_bot;
      logic [COORD_W-1:0] row_bot;
   } tag_type;

endpackage

### rtl/set_line_store.sv
// ----------------------------------------------------------------------------
// set_line_store
// Two previous image lines packed in one word per column: {line y-2, line y-1}.
// One read and one write port, registered read data.
// ----------------------------------------------------------------------------
module set_line_store #(
   parameter int DEPTH = 4096
) (
   input  logic                                clock,
   input  logic                                rd_en,
   input  logic [$clog2(DEPTH)-1:0]            rd_addr,
   output logic [set_pkg::LINE_W-1:0]          rd_data,
   input  logic                                wr_en,
   input  logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  logic [set_pkg::LINE_W-1:0]          wr_data
);

   logic [set_pkg::LINE_W-1:0] line_mem [DEPTH];
   logic [set_pkg::LINE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/set_window.sv
// ----------------------------------------------------------------------------
// set_window
// 3x3 window shift register and Sobel Gx/Gy sums; registers the gradient
// magnitudes of one item.
// ----------------------------------------------------------------------------
module set_window (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [set_pkg::PIX_W-1:0]     in_pix,
   input  logic [set_pkg::LINE_W-1:0]    in_line,
   input  set_pkg::tag_type              in_tag,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [set_pkg::MAG_W-1:0]     out_mag_x,
   output logic [set_pkg::MAG_W-1:0]     out_mag_y,
   output set_pkg::tag_type              out_tag
);

   localparam int PW = set_pkg::PIX_W;
   localparam int SW = set_pkg::MAG_W;

   // [0..2] column x-2 top..bottom, [3..5] column x-1
   logic [PW-1:0] window_ff [6];
   logic [PW-1:0] window_in [6];

   logic          valid_ff, valid_in;
   logic [SW-1:0] mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   set_pkg::tag_type tag_ff;

   logic [PW-1:0] t2, m2, b2;
   logic [SW-1:0] sum_r, sum_l, sum_t, sum_b;
   logic [SW:0]   diff_x, diff_y, abs_x, abs_y;
   logic          take;

   assign t2   = in_line[set_pkg::LINE_W-1:PW];
   assign m2   = in_line[PW-1:0];
   assign b2   = in_pix;
   assign in_ready = !valid_ff || out_ready;
   assign take = in_valid && in_ready;

   always_comb begin
      sum_r  = {2'b00, t2} + {1'b0, m2, 1'b0} + {2'b00, b2};
      sum_l  = {2'b00, window_ff[0]} + {1'b0, window_ff[1], 1'b0} + {2'b00, window_ff[2]};
      sum_t  = {2'b00, window_ff[0]} + {1'b0, window_ff[3], 1'b0} + {2'b00, t2};
      sum_b  = {2'b00, window_ff[2]} + {1'b0, window_ff[5], 1'b0} + {2'b00, b2};
      diff_x = {1'b0, sum_r} - {1'b0, sum_l};
      diff_y = {1'b0, sum_t} - {1'b0, sum_b};
      abs_x  = diff_x[SW] ? (~diff_x + 1'b1) : diff_x;
      abs_y  = diff_y[SW] ? (~diff_y + 1'b1) : diff_y;
      mag_x_in = abs_x[SW-1:0];
      mag_y_in = abs_y[SW-1:0];
   end

   always_comb begin
      window_in = window_ff;
      valid_in  = valid_ff;
      if (take) begin
         window_in[0] = window_ff[3];
         window_in[1] = window_ff[4];
         window_in[2] = window_ff[5];
         window_in[3] = t2;
         window_in[4] = m2;
         window_in[5] = b2;
         valid_in     = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         window_ff <= '{default: '0};
      end else begin
         valid_ff  <= valid_in;
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         mag_x_ff <= mag_x_in;
         mag_y_ff <= mag_y_in;
         tag_ff   <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_mag_x = mag_x_ff;
   assign out_mag_y = mag_y_ff;
   assign out_tag   = tag_ff;

endmodule

### rtl/set_magnitude.sv
// ----------------------------------------------------------------------------
// set_magnitude
// Squares the two gradient magnitudes of one item.
// ----------------------------------------------------------------------------
module set_magnitude (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [set_pkg::MAG_W-1:0]     in_mag_x,
   input  logic [set_pkg::MAG_W-1:0]     in_mag_y,
   input  set_pkg::tag_type              in_tag,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [set_pkg::SQ_W-1:0]      out_sq_x,
   output logic [set_pkg::SQ_W-1:0]      out_sq_y,
   output set_pkg::tag_type              out_tag
);

   localparam int MW = set_pkg::MAG_W;
   localparam int QW = set_pkg::SQ_W;

   logic             valid_ff, valid_in;
   logic [QW-1:0]    sq_x_ff, sq_x_in, sq_y_ff, sq_y_in;
   set_pkg::tag_type tag_ff;
   logic             take;

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;
   assign sq_x_in  = {{MW{1'b0}}, in_mag_x} * {{MW{1'b0}}, in_mag_x};
   assign sq_y_in  = {{MW{1'b0}}, in_mag_y} * {{MW{1'b0}}, in_mag_y};

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         sq_x_ff <= sq_x_in;
         sq_y_ff <= sq_y_in;
         tag_ff  <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_sq_x  = sq_x_ff;
   assign out_sq_y  = sq_y_ff;
   assign out_tag   = tag_ff;

endmodule

### rtl/set_result_queue.sv
// ----------------------------------------------------------------------------
// set_result_queue
// Threshold compare and result register; sends the up to three results of
// one item in order: interior pixel, right column, bottom row.
// ----------------------------------------------------------------------------
module set_result_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [set_pkg::SQ_W-1:0]       in_sq_x,
   input  logic [set_pkg::SQ_W-1:0]       in_sq_y,
   input  set_pkg::tag_type               in_tag,
   input  logic [set_pkg::TH2_W-1:0]      th2,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_edge_flag,
   output logic [set_pkg::COORD_W-1:0]    rsp_out_col,
   output logic [set_pkg::COORD_W-1:0]    rsp_out_row,
   output logic                           rsp_run_end
);

   localparam int QW = set_pkg::SQ_W;
   localparam int TW = set_pkg::TH2_W;
   localparam int SLOT_NORM  = 0;
   localparam int SLOT_RIGHT = 1;
   localparam int SLOT_BOT   = 2;

   logic [2:0]       slot_ff, slot_in;
   logic             flag_ff, flag_in;
   set_pkg::tag_type tag_ff;
   logic [QW:0]      sum_sq;
   logic             last, load, send;

   assign sum_sq    = {1'b0, in_sq_x} + {1'b0, in_sq_y};
   assign flag_in   = in_tag.calc && (TW'(sum_sq) > th2);
   assign rsp_valid = slot_ff != 3'b000;
   assign last      = rsp_valid && ((slot_ff & (slot_ff - 3'd1)) == 3'b000);
   assign send      = rsp_valid && rsp_ready;
   assign in_ready  = !rsp_valid || (rsp_ready && last);
   assign load      = in_valid && in_ready;

   always_comb begin
      slot_in = slot_ff;
      if (load) begin
         slot_in = {in_tag.has_bot, in_tag.has_right, in_tag.has_norm};
      end else if (send) begin
         slot_in = slot_ff & (slot_ff - 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= 3'b000;
      end else begin
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         flag_ff <= flag_in;
         tag_ff  <= in_tag;
      end
   end

   always_comb begin
      rsp_edge_flag = 1'b0;
      rsp_out_col   = tag_ff.col_norm;
      rsp_out_row   = tag_ff.row_norm;
      priority if (slot_ff[SLOT_NORM]) begin
         rsp_edge_flag = flag_ff;
      end else if (slot_ff[SLOT_RIGHT]) begin
         rsp_out_col = tag_ff.col_right;
      end else if (slot_ff[SLOT_BOT]) begin
         rsp_out_col = tag_ff.col_bot;
         rsp_out_row = tag_ff.row_bot;
      end else begin
         rsp_edge_flag = 1'b0;
      end
   end

   assign rsp_run_end = last;

   a_more_follow: assert property (@(posedge clock) disable iff (reset)
      send && !rsp_run_end |=> rsp_valid)
      else $error("result set ended early");

   a_edge_on_interior: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_edge_flag |-> slot_ff[SLOT_NORM])
      else $error("edge flag on a border result");

   a_load_when_drained: assert property (@(posedge clock) disable iff (reset)
      load && rsp_valid |-> rsp_ready && rsp_run_end)
      else $error("result set overwritten");

endmodule

### rtl/sobel_edge_threshold.sv
// ----------------------------------------------------------------------------
// sobel_edge_threshold
// Sobel 3x3 edge detector on a raster pixel stream with squared threshold.
// The first result of an item is offered from the result register, behind the
// input stage, window and magnitude registers. Throughput: one item per cycle
// while no stage stalls; an item with several results (up to three, at the right
// column and bottom row) holds the result register until its last one is sent.
// Reset: synchronous; clears position, window and valid bits, loads 640 / 480 /
// 100*100 into the width, height and squared threshold registers; line stores keep data.
module sobel_edge_threshold #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [set_pkg::PIX_W-1:0]         req_pixel,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_edge_flag,
   output logic [set_pkg::COORD_W-1:0]       rsp_out_col,
   output logic [set_pkg::COORD_W-1:0]       rsp_out_row,
   output logic                              rsp_run_end,
   input  logic                              csr_we,
   input  logic [set_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [set_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int AW  = $clog2(MAX_WIDTH);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int CW  = set_pkg::COORD_W;
   localparam int XW  = (WW > CW) ? WW : CW;
   localparam int HW  = set_pkg::HEIGHT_W;
   localparam int PW  = set_pkg::PIX_W;
   localparam int DW  = set_pkg::CSR_DATA_W;
   localparam int TW  = set_pkg::TH_W;
   localparam int T2W = set_pkg::TH2_W;
   localparam int W_RESET = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;

   // configuration, kept clamped
   logic [WW-1:0]  width_ff, width_in;
   logic [HW-1:0]  height_ff, height_in;
   logic [T2W-1:0] th2_ff, th2_in;
   logic [TW-1:0]  thr;

   logic [AW-1:0]  col_ff, col_in;
   logic [CW-1:0]  row_ff, row_in;
   logic [AW-1:0]  x;
   logic [CW-1:0]  y;
   logic [WW-1:0]  x_plus;
   logic [HW-1:0]  y_plus;
   logic [XW-1:0]  x_x, w_x;
   logic           accept;

   logic             s1_valid_ff, s1_valid_in;
   logic [PW-1:0]    s1_pix_ff;
   logic [AW-1:0]    s1_x_ff;
   set_pkg::tag_type s1_tag_ff, tag_in;
   logic             s1_take;

   logic [set_pkg::LINE_W-1:0] line_rd;
   logic                       win_ready, win_valid, mag_ready, mag_valid, q_ready;
   logic [set_pkg::MAG_W-1:0]  mag_x, mag_y;
   logic [set_pkg::SQ_W-1:0]   sq_x, sq_y;
   set_pkg::tag_type           win_tag, mag_tag;

   // configuration writes
   assign thr = csr_wdata[TW-1:0];

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      th2_in    = th2_ff;
      if (csr_we) begin
         unique case (csr_index)
            set_pkg::CSR_IMAGE_WIDTH: begin
               if (csr_wdata < DW'(set_pkg::MIN_SIZE)) begin
                  width_in = WW'(set_pkg::MIN_SIZE);
               end else if ({1'b0, csr_wdata} > (DW + 1)'(MAX_WIDTH)) begin
                  width_in = WW'(MAX_WIDTH);
               end else begin
                  width_in = WW'(csr_wdata);
               end
            end
            set_pkg::CSR_IMAGE_HEIGHT: begin
               if (csr_wdata < DW'(set_pkg::MIN_SIZE)) begin
                  height_in = HW'(set_pkg::MIN_SIZE);
               end else if (csr_wdata > DW'(set_pkg::MAX_HEIGHT)) begin
                  height_in = HW'(set_pkg::MAX_HEIGHT);
               end else begin
                  height_in = HW'(csr_wdata);
               end
            end
            set_pkg::CSR_EDGE_THRESHOLD: begin
               th2_in = {{TW{1'b0}}, thr} * {{TW{1'b0}}, thr};
            end
            default: begin
               th2_in = th2_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WW'(W_RESET);
         height_ff <= set_pkg::HEIGHT_RESET;
         th2_ff    <= set_pkg::TH2_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         th2_ff    <= th2_in;
      end
   end

   // position of the incoming item, wrapped after a size change
   assign accept    = req_valid && req_ready;
   assign s1_take   = s1_valid_ff && win_ready;
   assign req_ready = !s1_valid_ff || win_ready;

   always_comb begin
      x      = (WW'(col_ff) >= width_ff) ? '0 : col_ff;
      y      = ({1'b0, row_ff} >= height_ff) ? '0 : row_ff;
      x_plus = WW'(x) + WW'(1);
      y_plus = {1'b0, y} + HW'(1);
      x_x    = XW'(x);
      w_x    = XW'(width_ff);

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (x_plus >= width_ff) begin
            col_in = '0;
            row_in = (y_plus >= height_ff) ? '0 : y_plus[CW-1:0];
         end else begin
            col_in = x_plus[AW-1:0];
            row_in = y;
         end
      end

      tag_in.calc      = (WW'(x) >= WW'(2)) && (y >= CW'(2));
      tag_in.has_norm  = (x != '0) && (y != '0);
      tag_in.has_right = (WW'(x) == width_ff - WW'(1)) && (y != '0);
      tag_in.has_bot   = ({1'b0, y} == height_ff - HW'(1));
      tag_in.col_norm  = CW'(x_x - XW'(1));
      tag_in.row_norm  = y - CW'(1);
      tag_in.col_right = CW'(w_x - XW'(1));
      tag_in.col_bot   = CW'(x_x);
      tag_in.row_bot   = y;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (win_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff <= req_pixel;
         s1_x_ff   <= x;
         s1_tag_ff <= tag_in;
      end
   end

   set_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (x),
      .rd_data (line_rd),
      .wr_en   (s1_take),
      .wr_addr (s1_x_ff),
      .wr_data ({line_rd[PW-1:0], s1_pix_ff})
   );

   set_window u_window (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_ready  (win_ready),
      .in_pix    (s1_pix_ff),
      .in_line   (line_rd),
      .in_tag    (s1_tag_ff),
      .out_valid (win_valid),
      .out_ready (mag_ready),
      .out_mag_x (mag_x),
      .out_mag_y (mag_y),
      .out_tag   (win_tag)
   );

   set_magnitude u_magnitude (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (win_valid),
      .in_ready  (mag_ready),
      .in_mag_x  (mag_x),
      .in_mag_y  (mag_y),
      .in_tag    (win_tag),
      .out_valid (mag_valid),
      .out_ready (q_ready),
      .out_sq_x  (sq_x),
      .out_sq_y  (sq_y),
      .out_tag   (mag_tag)
   );

   set_result_queue u_result_queue (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (mag_valid),
      .in_ready      (q_ready),
      .in_sq_x       (sq_x),
      .in_sq_y       (sq_y),
      .in_tag        (mag_tag),
      .th2           (th2_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_edge_flag (rsp_edge_flag),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_row   (rsp_out_row),
      .rsp_run_end   (rsp_run_end)
   );

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !win_ready |=> s1_valid_ff && $stable(s1_x_ff) && $stable(s1_pix_ff))
      else $error("input stage item lost while stalled");

endmodule

### bench/sobel_edge_threshold_tb.sv
// ----------------------------------------------------------------------------
// sobel_edge_threshold_tb
// Self-checking bench for the Sobel edge threshold block. A queue-fed driver
// streams pixels over valid/ready while a clocked monitor predicts the edge
// results of each accepted item and checks every result in order. Runs short
// directed frames, a steady fill frame, then random phases with size and
// threshold changes between them, under random idling on both sides.
// ----------------------------------------------------------------------------
module sobel_edge_threshold_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PW = set_pkg::PIX_W;
   localparam int CW = set_pkg::COORD_W;
   localparam int IW = set_pkg::CSR_IDX_W;
   localparam int DW = set_pkg::CSR_DATA_W;
   localparam int HW = set_pkg::HEIGHT_W;
   localparam int TW = set_pkg::TH_W;

   localparam int LINE_DEPTH     = 4096;
   localparam int TIMEOUT_CYCLES = 500000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int RANDOM_ITEMS   = 330;
   localparam int TYP_WIDTH_MAX  = 12;

   typedef enum int {PIX_UNIFORM, PIX_BINARY, PIX_SMOOTH} pixel_style_type;

   typedef struct packed {
      logic          edge_flag;
      logic [CW-1:0] col;
      logic [CW-1:0] row;
      logic          run_end;
   } edge_result_type;

   logic           clock;
   logic           reset      = 1'b1;
   logic           req_valid  = 1'b0;
   logic           req_ready;
   logic [PW-1:0]  req_pixel  = '0;
   logic           rsp_valid;
   logic           rsp_ready  = 1'b0;
   logic           rsp_edge_flag;
   logic [CW-1:0]  rsp_out_col;
   logic [CW-1:0]  rsp_out_row;
   logic           rsp_run_end;
   logic           csr_we     = 1'b0;
   logic [IW-1:0]  csr_index  = '0;
   logic [DW-1:0]  csr_wdata  = '0;

   // predictor state
   logic [PW-1:0]      line_above  [LINE_DEPTH];
   logic [PW-1:0]      line_above2 [LINE_DEPTH];
   logic [PW-1:0]      win [6];
   int unsigned        col_pos = 0;
   int unsigned        row_pos = 0;
   logic [DW-1:0]      width_reg  = 13'd640;
   logic [HW-1:0]      height_reg = set_pkg::HEIGHT_RESET;
   logic [TW-1:0]      thresh_reg = 11'd100;

   edge_result_type    edge_results_q[$];
   logic [PW-1:0]      pixel_q[$];
   int                 errors = 0;
   int                 cycle_count = 0;
   bit                 steady = 1'b0;
   int                 smooth_level = 128;

   sobel_edge_threshold #(.MAX_WIDTH(LINE_DEPTH)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_pixel     (req_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_edge_flag (rsp_edge_flag),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_row   (rsp_out_row),
      .rsp_run_end   (rsp_run_end),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      foreach (line_above[i]) begin
         line_above[i]  = '0;
         line_above2[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      errors++;
   endtask

   task automatic sobel_predict(input logic [PW-1:0] pix);
      int unsigned     w, h, x, y;
      int              t0, m0, b0, t1, b1, t2, m2, b2, sx, sy;
      longint          mag2, th2;
      logic            flag;
      edge_result_type res[3];
      int              n;
      w = (width_reg < set_pkg::MIN_SIZE) ? set_pkg::MIN_SIZE :
          (width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg;
      h = (height_reg < set_pkg::MIN_SIZE) ? set_pkg::MIN_SIZE :
          (height_reg > set_pkg::MAX_HEIGHT) ? set_pkg::MAX_HEIGHT : height_reg;
      flag = 1'b0;
      n = 0;
      if (col_pos >= w) col_pos = 0;
      if (row_pos >= h) row_pos = 0;
      x = col_pos;
      y = row_pos;
      t0 = win[0]; m0 = win[1]; b0 = win[2];
      t1 = win[3]; b1 = win[5];
      t2 = line_above2[x]; m2 = line_above[x]; b2 = pix;
      if (x >= 2 && y >= 2) begin
         sx = (t2 + 2 * m2 + b2) - (t0 + 2 * m0 + b0);
         sy = (t0 + 2 * t1 + t2) - (b0 + 2 * b1 + b2);
         mag2 = sx * sx + sy * sy;
         th2 = thresh_reg;
         th2 = th2 * th2;
         flag = (mag2 > th2);
      end
      win[0] = win[3]; win[1] = win[4]; win[2] = win[5];
      win[3] = t2[PW-1:0];
      win[4] = m2[PW-1:0];
      win[5] = pix;
      line_above2[x] = m2[PW-1:0];
      line_above[x]  = pix;
      if (x >= 1 && y >= 1) begin
         res[n] = '{flag, CW'(x - 1), CW'(y - 1), 1'b0};
         n++;
      end
      if (x == w - 1 && y >= 1) begin
         res[n] = '{1'b0, CW'(w - 1), CW'(y - 1), 1'b0};
         n++;
      end
      if (y == h - 1) begin
         res[n] = '{1'b0, CW'(x), CW'(y), 1'b0};
         n++;
      end
      if (n > 0) res[n - 1].run_end = 1'b1;
      for (int i = 0; i < n; i++) edge_results_q.push_back(res[i]);
      if (x + 1 >= w) begin
         col_pos = 0;
         row_pos = (y + 1 >= h) ? 0 : y + 1;
      end else begin
         col_pos = x + 1;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pixel_q.size() != 0 && (steady || $urandom_range(99) >= 20)) begin
            req_valid <= 1'b1;
            req_pixel <= pixel_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !reset && (steady || $urandom_range(99) >= 20);
   end

   // monitor
   always @(posedge clock) begin : monitor
      edge_result_type got, want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_edge_flag, rsp_out_col, rsp_out_row, rsp_run_end};
            if (edge_results_q.size() == 0) begin
               report_mismatch($sformatf("result at (%0d,%0d) with none expected",
                                         got.col, got.row));
            end else begin
               want = edge_results_q.pop_front();
               if (got !== want)
                  report_mismatch($sformatf(
                     "got (%0d,%0d) flag %0b end %0b, expected (%0d,%0d) flag %0b end %0b",
                     got.col, got.row, got.edge_flag, got.run_end,
                     want.col, want.row, want.edge_flag, want.run_end));
            end
         end
         if (req_valid && req_ready) sobel_predict(req_pixel);
         if (csr_we) begin
            case (csr_index)
               set_pkg::CSR_IMAGE_WIDTH:    width_reg  = csr_wdata;
               set_pkg::CSR_IMAGE_HEIGHT:   height_reg = csr_wdata;
               set_pkg::CSR_EDGE_THRESHOLD: thresh_reg = csr_wdata[TW-1:0];
               default: ;
            endcase
         end
      end
   end

   initial begin
      while (cycle_count < TIMEOUT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sobel_edge_threshold regression: fail");
      $finish;
   end

   task automatic write_reg(input logic [IW-1:0] idx,
                            input logic [DW-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pixel_q.size() != 0 || req_valid || edge_results_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [PW-1:0] next_pixel(input pixel_style_type style);
      case (style)
         PIX_BINARY: return $urandom_range(1) ? 8'hFF : 8'h00;
         PIX_SMOOTH: begin
            smooth_level += int'($urandom_range(12)) - 6;
            if (smooth_level < 0)   smooth_level = 0;
            if (smooth_level > 255) smooth_level = 255;
            return smooth_level[PW-1:0];
         end
         default: return PW'($urandom_range(255));
      endcase
   endfunction

   task automatic push_pixels(input int count, input pixel_style_type style);
      @(negedge clock);
      repeat (count) pixel_q.push_back(next_pixel(style));
   endtask

   function automatic logic [DW-1:0] pick_size(input int typ_hi);
      int r;
      r = $urandom_range(99);
      if (r < 6)  return DW'($urandom_range(2));
      if (r < 10) return DW'($urandom_range(8191, 4097));
      return DW'($urandom_range(typ_hi, 3));
   endfunction

   initial begin : stimulus
      int            sent;
      int            count;
      int            r;
      int unsigned   mask;
      logic [DW-1:0] size;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // undersized frame saturates to 3x3; bottom row at full white, threshold zero
      write_reg(set_pkg::CSR_IMAGE_WIDTH, 13'd0);
      write_reg(set_pkg::CSR_IMAGE_HEIGHT, 13'd2);
      write_reg(set_pkg::CSR_EDGE_THRESHOLD, 13'd0);
      @(negedge clock);
      for (int i = 0; i < 9; i++) pixel_q.push_back(i >= 6 ? 8'hFF : 8'h00);
      wait_idle();

      // magnitude exactly at the threshold is not an edge
      write_reg(set_pkg::CSR_IMAGE_WIDTH, 13'd4);
      write_reg(set_pkg::CSR_IMAGE_HEIGHT, 13'd4);
      write_reg(set_pkg::CSR_EDGE_THRESHOLD, 13'd1020);
      @(negedge clock);
      for (int i = 0; i < 16; i++) pixel_q.push_back(i >= 8 ? 8'hFF : 8'h00);
      wait_idle();

      // fill the line store columns that random frames read, no idling
      steady = 1'b1;
      write_reg(set_pkg::CSR_IMAGE_WIDTH, DW'(TYP_WIDTH_MAX));
      write_reg(set_pkg::CSR_IMAGE_HEIGHT, 13'd4);
      write_reg(set_pkg::CSR_EDGE_THRESHOLD, DW'($urandom_range(800, 200)));
      push_pixels(4 * TYP_WIDTH_MAX, PIX_SMOOTH);
      wait_idle();
      steady = 1'b0;

      // random phases, sizes may change mid-frame
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         mask = $urandom_range(7, 1);
         if (mask[0]) begin
            size = pick_size(TYP_WIDTH_MAX);
            // wide rows only in the first two rows, where far columns feed no edge
            if (size > DW'(TYP_WIDTH_MAX) && row_pos >= 2)
               size = DW'($urandom_range(TYP_WIDTH_MAX, 3));
            write_reg(set_pkg::CSR_IMAGE_WIDTH, size);
         end
         if (mask[1]) write_reg(set_pkg::CSR_IMAGE_HEIGHT, pick_size(8));
         if (mask[2]) begin
            r = $urandom_range(99);
            if (r < 5)
               write_reg(set_pkg::CSR_EDGE_THRESHOLD, 13'd0);
            else if (r < 12)
               write_reg(set_pkg::CSR_EDGE_THRESHOLD, DW'($urandom_range(8191, 1443)));
            else
               write_reg(set_pkg::CSR_EDGE_THRESHOLD, DW'($urandom_range(400)));
         end
         steady = ($urandom_range(5) == 0);
         count = $urandom_range(48, 8);
         push_pixels(count, pixel_style_type'($urandom_range(2)));
         sent += count;
         wait_idle();
      end

      if (errors == 0) begin
         $display("sobel_edge_threshold regression: pass");
      end else begin
         $display("sobel_edge_threshold regression: fail");
      end
      $finish;
   end

endmodule

### sobel_edge_threshold.f
rtl/set_pkg.sv
rtl/set_line_store.sv
rtl/set_window.sv
rtl/set_magnitude.sv
rtl/set_result_queue.sv
rtl/sobel_edge_threshold.sv
bench/sobel_edge_threshold_tb.sv
